// ===== rtl/smcm_pkg.sv =====
// Shared constants, codes and the magic-sequence byte table.
// No dependencies.
package smcm_pkg;

    localparam int TEXT_BUFFER_BYTES = 2048;
    localparam int MAGIC_BYTES       = 12;
    localparam int NUM_SEQ           = 5;
    localparam int TAIL_LEN          = 4;
    localparam int PRE_LEN           = MAGIC_BYTES - TAIL_LEN;
    localparam int POS_W             = $clog2(TEXT_BUFFER_BYTES);
    localparam int IDX_W             = $clog2(MAGIC_BYTES);
    localparam int SEQ_W             = $clog2(NUM_SEQ);
    localparam int FLUSH_POS         = TEXT_BUFFER_BYTES - 4;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_RESET     = 3'd1,
        EV_BOOT_RST  = 3'd2,
        EV_PARALLEL  = 3'd3,
        EV_DATA_MODE = 3'd4,
        EV_TEXT_MODE = 3'd5
    } smcm_ev_t;

    typedef enum logic [2:0] {
        ACT_IGNORE   = 3'd0,
        ACT_DATA     = 3'd1,
        ACT_NEW_ROW  = 3'd2,
        ACT_APPEND   = 3'd3,
        ACT_LINE_END = 3'd4,
        ACT_HEX      = 3'd5
    } smcm_act_t;

    localparam logic [7:0] LF = 8'h0A;
    localparam logic [7:0] CR = 8'h0D;

    typedef logic [7:0] smcm_tail_t [NUM_SEQ][TAIL_LEN];

    localparam smcm_tail_t TAILS = '{
        '{8'h4E, 8'h52, 8'h53, 8'h54},
        '{8'h50, 8'h52, 8'h53, 8'h48},
        '{8'hBE, 8'hEF, 8'hBE, 8'hEF},
        '{8'hBE, 8'hEF, 8'hCA, 8'hFE},
        '{8'hF0, 8'h0F, 8'hCA, 8'hFE}
    };

    // Expected byte at window position pos for sequence seq
    function automatic logic [7:0] magic_byte(input logic [IDX_W-1:0] pos,
                                              input logic [SEQ_W-1:0] seq);
        logic [IDX_W-1:0] tail_idx;
        tail_idx = pos - IDX_W'(PRE_LEN);
        if (pos < IDX_W'(PRE_LEN))
            return pos[0] ? 8'hAA : 8'h55;
        else
            return TAILS[seq][tail_idx[1:0]];
    endfunction

endpackage

// ===== rtl/smcm_cell.sv =====
// One window cell: holds a byte, hands it to the left neighbor on shift,
// and flags which magic sequences its incoming byte matches. Uses smcm_pkg.
module smcm_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        shift_en,
    input  logic [smcm_pkg::IDX_W-1:0]  pos,
    input  logic [7:0]                  din,
    output logic [7:0]                  dout,
    output logic [smcm_pkg::NUM_SEQ-1:0] hit
);
    import smcm_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    assign byte_next = shift_en ? din : byte_reg;
    assign dout      = byte_reg;

    always_comb
    begin
        for (int s = 0; s < NUM_SEQ; s++)
        begin
            hit[s] = (din == magic_byte(pos, SEQ_W'(s)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

endmodule

// ===== rtl/smcm_window.sv =====
// Chain of window cells and the priority pick of the matched sequence.
// Uses smcm_pkg and smcm_cell.
module smcm_window (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               shift_en,
    input  logic [7:0]         rx_byte,
    output smcm_pkg::smcm_ev_t ev,
    output logic [7:0]         prev_byte
);
    import smcm_pkg::*;

    logic [7:0]         cell_dout [MAGIC_BYTES];
    logic [7:0]         cell_din  [MAGIC_BYTES];
    logic [NUM_SEQ-1:0] cell_hit  [MAGIC_BYTES];
    logic [NUM_SEQ-1:0] seq_hit;

    genvar p;
    generate
        for (p = 0; p < MAGIC_BYTES; p++)
        begin : g_cell
            if (p == MAGIC_BYTES - 1)
            begin : g_last
                assign cell_din[p] = rx_byte;
            end
            else
            begin : g_mid
                assign cell_din[p] = cell_dout[p+1];
            end

            smcm_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (shift_en),
                .pos      (IDX_W'(p)),
                .din      (cell_din[p]),
                .dout     (cell_dout[p]),
                .hit      (cell_hit[p])
            );
        end
    endgenerate

    // byte received just before the incoming one
    assign prev_byte = cell_dout[MAGIC_BYTES-1];

    always_comb
    begin
        seq_hit = '1;
        for (int c = 0; c < MAGIC_BYTES; c++)
        begin
            seq_hit = seq_hit & cell_hit[c];
        end
    end

    // first sequence in list order wins
    always_comb
    begin
        ev = EV_NONE;
        for (int s = NUM_SEQ - 1; s >= 0; s--)
        begin
            if (seq_hit[s])
                ev = smcm_ev_t'(3'(s + 1));
        end
    end

endmodule

// ===== rtl/magic_sequence_console_monitor_unit.sv =====
// Top level of the console monitor: mode, row, flush and text fill tracking.
// Uses smcm_pkg and smcm_window.
//
// Takes one debug byte per request and returns one result per byte. A byte
// may be taken every clock cycle; its result appears in the output register
// on the next cycle and a new byte is taken while that result waits, as long
// as res_ready is high or the output register is empty. The last 12 bytes sit
// in a chain of 12 cells that shift on each accepted byte and compare in
// parallel against the five magic sequences, so matching, mode switch and
// classification are combinational. The user must write flush_item_limit
// (cfg_we/cfg_data) only while no byte is in flight; it is not enforced.
module magic_sequence_console_monitor_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [7:0]                 cfg_data,
    input  logic                       rx_valid,
    output logic                       rx_ready,
    input  logic [7:0]                 rx_byte,
    output logic                       res_valid,
    input  logic                       res_ready,
    output logic [2:0]                 event_res,
    output logic                       mode_now,
    output logic [2:0]                 action,
    output logic [7:0]                 byte_out,
    output logic                       flushed,
    output logic [smcm_pkg::POS_W-1:0] fill_level
);
    import smcm_pkg::*;

    logic             accept;
    smcm_ev_t         ev;
    logic [7:0]       prev_byte;

    logic [7:0]       limit_reg;
    logic             text_mode_reg, text_mode_next;
    logic [3:0]       row_reg, row_next;
    logic [7:0]       items_reg, items_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    logic             valid_reg;
    logic [2:0]       ev_reg;
    logic             mode_reg;
    smcm_act_t        act_reg, act_next;
    logic [7:0]       byte_reg;
    logic             flush_reg, flush_next;
    logic [POS_W-1:0] fill_reg;

    assign rx_ready = !valid_reg || res_ready;
    assign accept   = rx_valid && rx_ready;

    smcm_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (accept),
        .rx_byte   (rx_byte),
        .ev        (ev),
        .prev_byte (prev_byte)
    );

    always_comb
    begin
        text_mode_next = text_mode_reg;
        row_next       = row_reg;
        pos_next       = pos_reg;
        flush_next     = 1'b0;
        act_next       = ACT_IGNORE;

        case (ev)
            EV_PARALLEL, EV_DATA_MODE:
            begin
                text_mode_next = 1'b0;
                row_next       = '0;
            end
            EV_TEXT_MODE:
            begin
                text_mode_next = 1'b1;
                pos_next       = '0;
            end
            default:
            begin
            end
        endcase

        items_next = items_reg + 8'd1;

        if (!text_mode_next)
        begin
            act_next = (row_next == 4'd0) ? ACT_NEW_ROW : ACT_DATA;
            row_next = row_next + 4'd1;
        end
        else
        begin
            if (pos_next >= POS_W'(FLUSH_POS) || items_next > limit_reg)
            begin
                flush_next = 1'b1;
                pos_next   = '0;
                items_next = '0;
            end
            if (rx_byte == 8'h00)
            begin
                act_next = ACT_IGNORE;
            end
            else if (rx_byte inside {8'hAA, 8'h1B, 8'h09, LF, CR, [8'h20:8'h7E]})
            begin
                if ((rx_byte == CR && prev_byte != LF) || rx_byte == LF)
                begin
                    act_next = ACT_LINE_END;
                    pos_next = '0;
                end
                else
                begin
                    act_next = ACT_APPEND;
                    pos_next = pos_next + POS_W'(1);
                end
            end
            else
            begin
                act_next = ACT_HEX;
                pos_next = pos_next + POS_W'(2);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= 8'd16;
            text_mode_reg <= 1'b1;
            row_reg       <= '0;
            items_reg     <= '0;
            pos_reg       <= '0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_data;
            if (accept)
            begin
                text_mode_reg <= text_mode_next;
                row_reg       <= row_next;
                items_reg     <= items_next;
                pos_reg       <= pos_next;
                valid_reg     <= 1'b1;
            end
            else if (res_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ev_reg    <= ev;
            mode_reg  <= text_mode_next;
            act_reg   <= act_next;
            byte_reg  <= rx_byte;
            flush_reg <= flush_next;
            fill_reg  <= pos_next;
        end
    end

    assign res_valid  = valid_reg;
    assign event_res  = ev_reg;
    assign mode_now   = mode_reg;
    assign action     = act_reg;
    assign byte_out   = byte_reg;
    assign flushed    = flush_reg;
    assign fill_level = fill_reg;

endmodule

// ===== rtl/smcm_checker.sv =====
// Port-level checks for the console monitor, bound to the top level.
// Uses smcm_pkg.
module smcm_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       res_valid,
    input logic                       res_ready,
    input logic [2:0]                 event_res,
    input logic                       mode_now,
    input logic [2:0]                 action,
    input logic [7:0]                 byte_out,
    input logic                       flushed,
    input logic [smcm_pkg::POS_W-1:0] fill_level
);
    import smcm_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(byte_out)
            && $stable(action) && $stable(fill_level))
        else $error("stalled result changed");

    a_data_mode: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !mode_now |-> !flushed
            && (action == ACT_DATA || action == ACT_NEW_ROW))
        else $error("bad data-mode result");

    a_switch: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (event_res == EV_PARALLEL || event_res == EV_DATA_MODE)
            |-> !mode_now && action == ACT_NEW_ROW)
        else $error("data switch not applied");

    a_text: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && event_res == EV_TEXT_MODE |-> mode_now)
        else $error("text switch not applied");

    a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && action == ACT_LINE_END |-> fill_level == '0)
        else $error("line end left position");

endmodule

bind magic_sequence_console_monitor_unit smcm_checker u_smcm_checker (.*);
